@@ rtl/nhqp_pkg.sv @@
package nhqp_pkg;

    localparam int ADMIN_DEPTH = 64;
    localparam int IO_DEPTH    = 128;

    localparam int ADMIN_PTR_W = (ADMIN_DEPTH > 1) ? $clog2(ADMIN_DEPTH) : 1;
    localparam int IO_PTR_W    = (IO_DEPTH > 1) ? $clog2(IO_DEPTH) : 1;

    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;
    localparam int DBOFF_W  = 19;
    localparam int DBVAL_W  = 8;
    localparam int CID_W    = 16;
    localparam int STRIDE_W = 4;
    localparam int TMO_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DBOFF_W-1:0] DB_BASE = 19'h01000;

    localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
    localparam logic [OP_W-1:0] OP_CPL    = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SUBMITTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE_OK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE_ERR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_READY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BUSY      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd300;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            queue_sel;
        logic [7:0]      opcode;
        logic [15:0]     cqe_status;
        logic [31:0]     cqe_result;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               queue_id;
        logic               doorbell_write;
        logic [DBOFF_W-1:0] doorbell_offset;
        logic [DBVAL_W-1:0] doorbell_value;
        logic [31:0]        command_word;
        logic [7:0]         sq_slot;
        logic [7:0]         status_code;
        logic [2:0]         status_type;
        logic [31:0]        result_dword;
    } t_result;

endpackage

@@ rtl/nhqp_in_reg.sv @@
module nhqp_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  nhqp_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output nhqp_pkg::t_item o_item
);
    import nhqp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load    = !r_valid || i_advance;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/nhqp_core.sv @@
module nhqp_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nhqp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nhqp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_fire,
    input  nhqp_pkg::t_item                      i_item,
    output logic                                 o_res_valid,
    output nhqp_pkg::t_result                    o_res
);
    import nhqp_pkg::*;

    logic [STRIDE_W-1:0]    r_stride;
    logic [TMO_W-1:0]       r_timeout;

    logic                   r_busy, n_busy;
    logic                   r_busy_queue, n_busy_queue;
    logic [TMO_W-1:0]       r_wait_count, n_wait_count;
    logic [ADMIN_PTR_W-1:0] r_admin_tail, n_admin_tail;
    logic [ADMIN_PTR_W-1:0] r_admin_head, n_admin_head;
    logic                   r_admin_phase, n_admin_phase;
    logic [IO_PTR_W-1:0]    r_io_tail, n_io_tail;
    logic [IO_PTR_W-1:0]    r_io_head, n_io_head;
    logic                   r_io_phase, n_io_phase;
    logic [CID_W-1:0]       r_cid_ctr, n_cid_ctr;

    logic [ADMIN_PTR_W-1:0] admin_tail_inc, admin_head_inc;
    logic [IO_PTR_W-1:0]    io_tail_inc, io_head_inc;
    logic [CID_W-1:0]       cid_inc;
    logic [DBOFF_W-1:0]     sq_db_off, cq_db_off;
    logic [7:0]             sc;
    logic [2:0]             sct;
    logic                   cur_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride  <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRIDE:  r_stride  <= i_cfg_data[STRIDE_W-1:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // pointer increments modulo the queue depth
    assign admin_tail_inc = (r_admin_tail == ADMIN_PTR_W'(ADMIN_DEPTH - 1)) ? '0
                          : r_admin_tail + 1'b1;
    assign admin_head_inc = (r_admin_head == ADMIN_PTR_W'(ADMIN_DEPTH - 1)) ? '0
                          : r_admin_head + 1'b1;
    assign io_tail_inc    = (r_io_tail == IO_PTR_W'(IO_DEPTH - 1)) ? '0 : r_io_tail + 1'b1;
    assign io_head_inc    = (r_io_head == IO_PTR_W'(IO_DEPTH - 1)) ? '0 : r_io_head + 1'b1;

    // command id skips zero on wrap
    assign cid_inc = (r_cid_ctr == '1) ? CID_W'(1) : r_cid_ctr + 1'b1;

    // doorbell index is 2*q for the tail and 2*q+1 for the head, step is 4 << stride
    assign sq_db_off = DB_BASE
                     + (DBOFF_W'({i_item.queue_sel, 1'b0}) << (5'(r_stride) + 5'd2));
    assign cq_db_off = DB_BASE
                     + (DBOFF_W'({r_busy_queue, 1'b1}) << (5'(r_stride) + 5'd2));

    assign sc        = i_item.cqe_status[8:1];
    assign sct       = i_item.cqe_status[11:9];
    assign cur_phase = r_busy_queue ? r_io_phase : r_admin_phase;

    always_comb begin
        n_busy        = r_busy;
        n_busy_queue  = r_busy_queue;
        n_wait_count  = r_wait_count;
        n_admin_tail  = r_admin_tail;
        n_admin_head  = r_admin_head;
        n_admin_phase = r_admin_phase;
        n_io_tail     = r_io_tail;
        n_io_head     = r_io_head;
        n_io_phase    = r_io_phase;
        n_cid_ctr     = r_cid_ctr;
        o_res_valid   = 1'b0;
        o_res         = '0;
        unique case (i_item.op)
            OP_SUBMIT: begin
                o_res_valid    = 1'b1;
                o_res.queue_id = i_item.queue_sel;
                if (r_busy) begin
                    o_res.kind = KIND_BUSY;
                end else begin
                    n_cid_ctr    = cid_inc;
                    n_busy       = 1'b1;
                    n_busy_queue = i_item.queue_sel;
                    n_wait_count = '0;
                    o_res.kind            = KIND_SUBMITTED;
                    o_res.doorbell_write  = 1'b1;
                    o_res.doorbell_offset = sq_db_off;
                    o_res.command_word    = {r_cid_ctr, 8'h00, i_item.opcode};
                    if (i_item.queue_sel) begin
                        n_io_tail            = io_tail_inc;
                        o_res.sq_slot        = 8'(r_io_tail);
                        o_res.doorbell_value = DBVAL_W'(io_tail_inc);
                    end else begin
                        n_admin_tail         = admin_tail_inc;
                        o_res.sq_slot        = 8'(r_admin_tail);
                        o_res.doorbell_value = DBVAL_W'(admin_tail_inc);
                    end
                end
            end
            OP_CPL, OP_TICK: begin
                if (!r_busy) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_IGNORED;
                end else if (i_item.op == OP_CPL) begin
                    o_res_valid    = 1'b1;
                    o_res.queue_id = r_busy_queue;
                    if (i_item.cqe_status[0] != cur_phase) begin
                        o_res.kind = KIND_NOT_READY;
                    end else begin
                        n_busy       = 1'b0;
                        n_wait_count = '0;
                        o_res.kind            = (sc != '0 || sct != '0) ? KIND_DONE_ERR
                                                                        : KIND_DONE_OK;
                        o_res.doorbell_write  = 1'b1;
                        o_res.doorbell_offset = cq_db_off;
                        o_res.status_code     = sc;
                        o_res.status_type     = sct;
                        o_res.result_dword    = i_item.cqe_result;
                        if (r_busy_queue) begin
                            n_io_head            = io_head_inc;
                            o_res.doorbell_value = DBVAL_W'(io_head_inc);
                            if (io_head_inc == '0) begin
                                n_io_phase = ~r_io_phase;
                            end
                        end else begin
                            n_admin_head         = admin_head_inc;
                            o_res.doorbell_value = DBVAL_W'(admin_head_inc);
                            if (admin_head_inc == '0) begin
                                n_admin_phase = ~r_admin_phase;
                            end
                        end
                    end
                end else if (r_wait_count >= r_timeout) begin
                    o_res_valid    = 1'b1;
                    o_res.queue_id = r_busy_queue;
                    o_res.kind     = KIND_TIMEOUT;
                    n_busy         = 1'b0;
                    n_wait_count   = '0;
                end else begin
                    n_wait_count = r_wait_count + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_busy_queue  <= 1'b0;
            r_wait_count  <= '0;
            r_admin_tail  <= '0;
            r_admin_head  <= '0;
            r_admin_phase <= 1'b1;
            r_io_tail     <= '0;
            r_io_head     <= '0;
            r_io_phase    <= 1'b1;
            r_cid_ctr     <= CID_W'(1);
        end else if (i_fire) begin
            r_busy        <= n_busy;
            r_busy_queue  <= n_busy_queue;
            r_wait_count  <= n_wait_count;
            r_admin_tail  <= n_admin_tail;
            r_admin_head  <= n_admin_head;
            r_admin_phase <= n_admin_phase;
            r_io_tail     <= n_io_tail;
            r_io_head     <= n_io_head;
            r_io_phase    <= n_io_phase;
            r_cid_ctr     <= n_cid_ctr;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_wait_count == '0)
        else $error("wait count nonzero while idle");

    a_cid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cid_ctr != '0)
        else $error("command id reached zero");

    a_submit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !r_busy && i_item.op == OP_SUBMIT |=> r_busy)
        else $error("accepted submit did not mark engine busy");

    a_reject_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_busy && i_item.op == OP_SUBMIT |=> r_busy && $stable(r_cid_ctr))
        else $error("submit while busy changed state");
`endif

endmodule

@@ rtl/nhqp_out_reg.sv @@
module nhqp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nhqp_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output nhqp_pkg::t_result o_res
);
    import nhqp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/nvme_host_queue_pair_engine_unit.sv @@
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  op, queue_sel, opcode, cqe_status, cqe_result
// out       output     o_out_valid / i_out_stall kind, queue_id, doorbell_*, command_word,
//                                               sq_slot, status_code, status_type, result_dword
// cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// one beat per cycle unless output stalls; a beat passes the input, then the output register
// an input register feeds the queue state logic, which loads one output register
// ticks that only count and unused op codes produce no output beat
// reset is synchronous and active low; pointers, phases and the command id take reset values
// a stalled output holds the input register, which then stalls the input side
module nvme_host_queue_pair_engine_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nhqp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nhqp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [nhqp_pkg::OP_W-1:0]            i_op,
    input  logic                                 i_queue_sel,
    input  logic [7:0]                           i_opcode,
    input  logic [15:0]                          i_cqe_status,
    input  logic [31:0]                          i_cqe_result,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [nhqp_pkg::KIND_W-1:0]          o_kind,
    output logic                                 o_queue_id,
    output logic                                 o_doorbell_write,
    output logic [nhqp_pkg::DBOFF_W-1:0]         o_doorbell_offset,
    output logic [nhqp_pkg::DBVAL_W-1:0]         o_doorbell_value,
    output logic [31:0]                          o_command_word,
    output logic [7:0]                           o_sq_slot,
    output logic [7:0]                           o_status_code,
    output logic [2:0]                           o_status_type,
    output logic [31:0]                          o_result_dword
);
    import nhqp_pkg::*;

    t_item   in_item, held_item;
    t_result core_res, out_res;
    logic    held_valid;
    logic    out_ready;
    logic    fire;
    logic    res_valid;

    assign in_item = '{op: i_op, queue_sel: i_queue_sel, opcode: i_opcode,
                       cqe_status: i_cqe_status, cqe_result: i_cqe_result};

    // the held beat moves on whenever the output register can take a result
    assign fire = held_valid && out_ready;

    nhqp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (fire),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    nhqp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    nhqp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (core_res),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_kind            = out_res.kind;
    assign o_queue_id        = out_res.queue_id;
    assign o_doorbell_write  = out_res.doorbell_write;
    assign o_doorbell_offset = out_res.doorbell_offset;
    assign o_doorbell_value  = out_res.doorbell_value;
    assign o_command_word    = out_res.command_word;
    assign o_sq_slot         = out_res.sq_slot;
    assign o_status_code     = out_res.status_code;
    assign o_status_type     = out_res.status_type;
    assign o_result_dword    = out_res.result_dword;

endmodule
